/* sv/dcle_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// dcle_pkg
// Types and constants shared by the DHCP client lease engine.
// ---------------------------------------------------------------------------
package dcle_pkg;

  localparam int TIME_BITS_DEF = 48;
  localparam int OQ_DEPTH      = 4;

  localparam logic [7:0]  HDR_LEN        = 8'd240;
  localparam logic [31:0] MAGIC_COOKIE   = 32'h63825363;
  localparam logic [15:0] RETRY_BASE_RST = 16'd2000;
  localparam logic [16:0] RENEW_CAP_S    = 17'd86400;
  localparam logic [31:0] LEASE_LIMIT_S  = 32'd172800;
  localparam logic [26:0] MS_PER_S       = 27'd1000;
  localparam logic [31:0] DEF_NETMASK    = 32'hFFFFFF00;

  // input modes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_BYTE  = 2'd2;

  // result actions
  localparam logic [1:0] ACT_DISCOVER = 2'd0;
  localparam logic [1:0] ACT_REQUEST  = 2'd1;
  localparam logic [1:0] ACT_BOUND    = 2'd2;
  localparam logic [1:0] ACT_RELEASED = 2'd3;

  // configuration register indexes
  localparam logic CFG_MAC   = 1'b0;
  localparam logic CFG_RETRY = 1'b1;

  // message types
  localparam logic [7:0] MSG_OFFER = 8'd2;
  localparam logic [7:0] MSG_ACK   = 8'd5;
  localparam logic [7:0] MSG_NAK   = 8'd6;

  // option codes
  localparam logic [7:0] OPT_PAD    = 8'd0;
  localparam logic [7:0] OPT_MASK   = 8'd1;
  localparam logic [7:0] OPT_ROUTER = 8'd3;
  localparam logic [7:0] OPT_DNS    = 8'd6;
  localparam logic [7:0] OPT_LEASE  = 8'd51;
  localparam logic [7:0] OPT_TYPE   = 8'd53;
  localparam logic [7:0] OPT_SERVER = 8'd54;
  localparam logic [7:0] OPT_END    = 8'd255;

  typedef enum logic [1:0] {
    PH_IDLE, PH_SELECTING, PH_REQUESTING, PH_BOUND
  } phase_t;

  typedef enum logic [1:0] {
    OP_CODE, OP_LEN, OP_VALUE, OP_DONE
  } opt_phase_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [47:0] now_ms;
    logic [7:0]  rx_byte;
    logic        last_byte;
    logic [31:0] random_xid;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] transaction_id;
    logic [31:0] requested_ip;
    logic [31:0] server_ip;
    logic [31:0] leased_address;
    logic [31:0] subnet_mask;
    logic [31:0] gateway_ip;
    logic [31:0] name_server_ip;
    logic        last_result;
  } out_item_t;

  // what the parser hands to the client state machine on a message byte
  typedef struct packed {
    logic        finish;
    logic [7:0]  msg_type;
    logic [31:0] your_addr;
    logic [31:0] server_id;
    logic [31:0] lease_s;
    logic [31:0] netmask;
    logic [31:0] router;
    logic [31:0] name_server;
  } msg_info_t;

endpackage
`default_nettype wire

/* sv/dcle_parser.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// dcle_parser
// Checks the fixed header and streams the options of a received message.
// ---------------------------------------------------------------------------
module dcle_parser (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                take,
  input  wire logic [7:0]          rx_byte,
  input  wire logic                last_byte,
  input  wire logic [31:0]         cur_xid,
  input  wire logic [47:0]         mac,
  output dcle_pkg::msg_info_t      info
);

  logic [7:0]  byte_position, byte_position_next;
  logic        header_matches, header_matches_next;
  dcle_pkg::opt_phase_t option_phase, option_phase_next;
  logic [7:0]  option_code_held, option_code_held_next;
  logic [7:0]  option_bytes_left, option_bytes_left_next;
  logic [31:0] option_value_held, option_value_held_next;
  logic [2:0]  option_value_count, option_value_count_next;
  logic [7:0]  seen_type, seen_type_next;
  logic [31:0] seen_mask, seen_mask_next;
  logic [31:0] seen_router, seen_router_next;
  logic [31:0] seen_dns, seen_dns_next;
  logic [31:0] seen_server, seen_server_next;
  logic [31:0] seen_lease, seen_lease_next;
  logic [31:0] seen_your, seen_your_next;

  logic [31:0] xid_sh, magic_sh, type_sh;
  logic [47:0] mac_sh;
  logic [2:0]  mac_k;
  logic [1:0]  type_k;
  logic        mism;

  always_comb begin
    mac_k    = 3'(byte_position - 8'd28);
    xid_sh   = cur_xid >> {~byte_position[1:0], 3'b000};
    magic_sh = dcle_pkg::MAGIC_COOKIE >> {~byte_position[1:0], 3'b000};
    mac_sh   = mac >> {3'(3'd5 - mac_k), 3'b000};
  end

  always_comb begin
    byte_position_next      = byte_position;
    header_matches_next     = header_matches;
    option_phase_next       = option_phase;
    option_code_held_next   = option_code_held;
    option_bytes_left_next  = option_bytes_left;
    option_value_held_next  = option_value_held;
    option_value_count_next = option_value_count;
    seen_type_next          = seen_type;
    seen_mask_next          = seen_mask;
    seen_router_next        = seen_router;
    seen_dns_next           = seen_dns;
    seen_server_next        = seen_server;
    seen_lease_next         = seen_lease;
    seen_your_next          = seen_your;
    mism                    = 1'b0;
    type_k                  = 2'(option_value_count - 3'd1);
    type_sh                 = '0;

    if (byte_position < dcle_pkg::HDR_LEN) begin
      byte_position_next = byte_position + 8'd1;
      if (byte_position == 8'd0) begin
        mism = (rx_byte != 8'd2);
      end else if (byte_position >= 8'd4 && byte_position < 8'd8) begin
        mism = (rx_byte != xid_sh[7:0]);
      end else if (byte_position >= 8'd16 && byte_position < 8'd20) begin
        seen_your_next = {seen_your[23:0], rx_byte};
      end else if (byte_position >= 8'd28 && byte_position < 8'd34) begin
        mism = (rx_byte != mac_sh[7:0]);
      end else if (byte_position >= 8'd236) begin
        mism = (rx_byte != magic_sh[7:0]);
      end
      if (mism) header_matches_next = 1'b0;
    end else begin
      case (option_phase)
        dcle_pkg::OP_CODE: begin
          if (rx_byte == dcle_pkg::OPT_END) begin
            option_phase_next = dcle_pkg::OP_DONE;
          end else if (rx_byte != dcle_pkg::OPT_PAD) begin
            option_code_held_next = rx_byte;
            option_phase_next     = dcle_pkg::OP_LEN;
          end
        end
        dcle_pkg::OP_LEN: begin
          option_bytes_left_next  = rx_byte;
          option_value_held_next  = '0;
          option_value_count_next = '0;
          option_phase_next = (rx_byte == 8'd0) ? dcle_pkg::OP_CODE : dcle_pkg::OP_VALUE;
        end
        dcle_pkg::OP_VALUE: begin
          if (option_value_count < 3'd4) begin
            option_value_held_next  = {option_value_held[23:0], rx_byte};
            option_value_count_next = option_value_count + 3'd1;
          end
          option_bytes_left_next = option_bytes_left - 8'd1;
          if (option_bytes_left_next == 8'd0) begin
            option_phase_next = dcle_pkg::OP_CODE;
            if (option_code_held == dcle_pkg::OPT_TYPE) begin
              // first value byte is the type
              type_k  = 2'(option_value_count_next - 3'd1);
              type_sh = option_value_held_next >> {type_k, 3'b000};
              seen_type_next = type_sh[7:0];
            end else if (option_value_count_next >= 3'd4) begin
              case (option_code_held)
                dcle_pkg::OPT_MASK:   seen_mask_next   = option_value_held_next;
                dcle_pkg::OPT_ROUTER: seen_router_next = option_value_held_next;
                dcle_pkg::OPT_DNS:    seen_dns_next    = option_value_held_next;
                dcle_pkg::OPT_SERVER: seen_server_next = option_value_held_next;
                dcle_pkg::OPT_LEASE:  seen_lease_next  = option_value_held_next;
                default: ;
              endcase
            end
          end
        end
        default: ;
      endcase
    end

    info.finish      = last_byte && (byte_position >= 8'(dcle_pkg::HDR_LEN - 8'd1))
                       && header_matches_next;
    info.msg_type    = seen_type_next;
    info.your_addr   = seen_your_next;
    info.server_id   = seen_server_next;
    info.lease_s     = seen_lease_next;
    info.netmask     = seen_mask_next;
    info.router      = seen_router_next;
    info.name_server = seen_dns_next;

    if (last_byte) begin
      byte_position_next      = '0;
      header_matches_next     = 1'b1;
      option_phase_next       = dcle_pkg::OP_CODE;
      option_code_held_next   = '0;
      option_bytes_left_next  = '0;
      option_value_held_next  = '0;
      option_value_count_next = '0;
      seen_type_next          = '0;
      seen_mask_next          = '0;
      seen_router_next        = '0;
      seen_dns_next           = '0;
      seen_server_next        = '0;
      seen_lease_next         = '0;
      seen_your_next          = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      header_matches     <= 1'b1;
      option_phase       <= dcle_pkg::OP_CODE;
      option_code_held   <= '0;
      option_bytes_left  <= '0;
      option_value_held  <= '0;
      option_value_count <= '0;
      seen_type          <= '0;
      seen_mask          <= '0;
      seen_router        <= '0;
      seen_dns           <= '0;
      seen_server        <= '0;
      seen_lease         <= '0;
      seen_your          <= '0;
    end else if (take) begin
      byte_position      <= byte_position_next;
      header_matches     <= header_matches_next;
      option_phase       <= option_phase_next;
      option_code_held   <= option_code_held_next;
      option_bytes_left  <= option_bytes_left_next;
      option_value_held  <= option_value_held_next;
      option_value_count <= option_value_count_next;
      seen_type          <= seen_type_next;
      seen_mask          <= seen_mask_next;
      seen_router        <= seen_router_next;
      seen_dns           <= seen_dns_next;
      seen_server        <= seen_server_next;
      seen_lease         <= seen_lease_next;
      seen_your          <= seen_your_next;
    end
  end

endmodule
`default_nettype wire

/* sv/dcle_fsm.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// dcle_fsm
// Client phase, retransmission and renewal timers, result generation.
// ---------------------------------------------------------------------------
module dcle_fsm #(
  parameter int TIME_BITS = dcle_pkg::TIME_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                take,
  input  wire dcle_pkg::in_item_t  item,
  input  wire dcle_pkg::msg_info_t info,
  input  wire logic [15:0]         retry_base,
  output logic [31:0]              cur_xid,
  output dcle_pkg::phase_t         phase,
  output dcle_pkg::out_item_t      res0,
  output dcle_pkg::out_item_t      res1,
  output logic [1:0]               n_res
);

  dcle_pkg::phase_t     phase_next;
  logic [31:0]          xid_next, offered, offered_next, server, server_next;
  logic [TIME_BITS-1:0] send_due, send_due_next, renew, renew_next;
  logic [2:0]           retry_count, retry_count_next, rc_inc;
  logic [63:0]          now_w;
  logic [TIME_BITS-1:0] now_t, sum_base, sum_backoff;
  logic [1:0]           shamt;
  logic [18:0]          base_sh;
  logic [16:0]          secs;
  logic [26:0]          lease_ms;
  logic                 restart;

  always_comb begin
    now_w       = {16'b0, item.now_ms};
    now_t       = now_w[TIME_BITS-1:0];
    sum_base    = now_t + TIME_BITS'(retry_base);
    rc_inc      = (retry_count < 3'd4) ? retry_count + 3'd1 : retry_count;
    shamt       = (rc_inc >= 3'd3) ? 2'd3 : rc_inc[1:0];
    base_sh     = {3'b000, retry_base} << shamt;
    sum_backoff = now_t + TIME_BITS'(base_sh);
    if (info.lease_s != 32'd0 && info.lease_s < dcle_pkg::LEASE_LIMIT_S)
      secs = 17'(info.lease_s >> 1);
    else
      secs = dcle_pkg::RENEW_CAP_S;
    if (secs == 17'd0) secs = 17'd1;
    lease_ms = 27'(secs) * dcle_pkg::MS_PER_S;
  end

  always_comb begin
    phase_next       = phase;
    xid_next         = cur_xid;
    offered_next     = offered;
    server_next      = server;
    send_due_next    = send_due;
    renew_next       = renew;
    retry_count_next = retry_count;
    restart          = 1'b0;
    n_res            = 2'd0;
    res0             = '0;
    res1             = '0;

    case (item.mode)
      dcle_pkg::MODE_START: restart = 1'b1;
      dcle_pkg::MODE_TICK: begin
        if (phase == dcle_pkg::PH_BOUND) begin
          if (now_t >= renew) begin
            phase_next       = dcle_pkg::PH_REQUESTING;
            retry_count_next = '0;
            send_due_next    = sum_base;
            res0.action         = dcle_pkg::ACT_REQUEST;
            res0.transaction_id = cur_xid;
            res0.requested_ip   = offered;
            res0.server_ip      = server;
            n_res               = 2'd1;
          end
        end else if (phase != dcle_pkg::PH_IDLE && now_t >= send_due) begin
          retry_count_next = rc_inc;
          send_due_next    = sum_backoff;
          if (phase == dcle_pkg::PH_REQUESTING && rc_inc > 3'd3) begin
            restart = 1'b1;
          end else if (phase == dcle_pkg::PH_REQUESTING) begin
            res0.action         = dcle_pkg::ACT_REQUEST;
            res0.transaction_id = cur_xid;
            res0.requested_ip   = offered;
            res0.server_ip      = server;
            n_res               = 2'd1;
          end else begin
            res0.action         = dcle_pkg::ACT_DISCOVER;
            res0.transaction_id = cur_xid;
            n_res               = 2'd1;
          end
        end
      end
      dcle_pkg::MODE_BYTE: begin
        if (info.finish && phase != dcle_pkg::PH_IDLE) begin
          if (info.msg_type == dcle_pkg::MSG_OFFER && phase == dcle_pkg::PH_SELECTING) begin
            offered_next     = info.your_addr;
            server_next      = info.server_id;
            phase_next       = dcle_pkg::PH_REQUESTING;
            retry_count_next = '0;
            send_due_next    = sum_base;
            res0.action         = dcle_pkg::ACT_REQUEST;
            res0.transaction_id = cur_xid;
            res0.requested_ip   = info.your_addr;
            res0.server_ip      = info.server_id;
            n_res               = 2'd1;
          end else if (info.msg_type == dcle_pkg::MSG_ACK
                       && phase == dcle_pkg::PH_REQUESTING) begin
            phase_next = dcle_pkg::PH_BOUND;
            renew_next = now_t + TIME_BITS'(lease_ms);
            res0.action         = dcle_pkg::ACT_BOUND;
            res0.leased_address = info.your_addr;
            res0.subnet_mask    = (info.netmask != 32'd0) ? info.netmask
                                                          : dcle_pkg::DEF_NETMASK;
            res0.gateway_ip     = info.router;
            res0.name_server_ip = info.name_server;
            n_res               = 2'd1;
          end else if (info.msg_type == dcle_pkg::MSG_NAK) begin
            res0.action = dcle_pkg::ACT_RELEASED;
            n_res       = 2'd1;
            restart     = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (restart) begin
      xid_next         = item.random_xid;
      phase_next       = dcle_pkg::PH_SELECTING;
      retry_count_next = '0;
      send_due_next    = sum_base;
      // a nak puts the discover behind the release
      if (n_res == 2'd1) begin
        res1.action         = dcle_pkg::ACT_DISCOVER;
        res1.transaction_id = item.random_xid;
        n_res               = 2'd2;
      end else begin
        res0.action         = dcle_pkg::ACT_DISCOVER;
        res0.transaction_id = item.random_xid;
        n_res               = 2'd1;
      end
    end

    res0.last_result = (n_res == 2'd1);
    res1.last_result = (n_res == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= dcle_pkg::PH_IDLE;
      cur_xid     <= '0;
      offered     <= '0;
      server      <= '0;
      send_due    <= '0;
      renew       <= '0;
      retry_count <= '0;
    end else if (take) begin
      phase       <= phase_next;
      cur_xid     <= xid_next;
      offered     <= offered_next;
      server      <= server_next;
      send_due    <= send_due_next;
      renew       <= renew_next;
      retry_count <= retry_count_next;
    end
  end

endmodule
`default_nettype wire

/* sv/dcle_outq.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// dcle_outq
// Small result queue: up to two pushes a cycle, one pop while not stalled.
// ---------------------------------------------------------------------------
module dcle_outq #(
  parameter int DEPTH = dcle_pkg::OQ_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [1:0]          push,
  input  wire dcle_pkg::out_item_t d0,
  input  wire dcle_pkg::out_item_t d1,
  output logic                     nearly_full,
  output logic [$clog2(DEPTH):0]   level,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output dcle_pkg::out_item_t      out_data
);

  localparam int AW = $clog2(DEPTH);

  dcle_pkg::out_item_t mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic          pop;

  assign pop         = out_valid && !out_stall;
  assign out_valid   = (level != '0);
  assign out_data    = mem[rptr];
  assign nearly_full = (level > (AW+1)'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push != 2'd0) mem[wptr] <= d0;
    if (push == 2'd2) mem[AW'(wptr + AW'(1))] <= d1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      wptr  <= AW'(wptr + AW'(push));
      rptr  <= AW'(rptr + AW'(pop));
      level <= level + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

/* sv/dhcp_client_lease_engine_top.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// dhcp_client_lease_engine_top
// DHCP client for one interface: header check, option parse, lease phases.
// ---------------------------------------------------------------------------
// Results enter the result queue as their item is taken and leave in order.
// Throughput: one item per cycle; a nak gives two results, which leave the
// four-entry result queue one per cycle unless out_stall is set; input
// stalls with under two free. Reset (synchronous, rst high): client idle,
// parser cleared, queue empty, retry base 2000 ms, hardware address zero.
module dhcp_client_lease_engine_top #(
  parameter int TIME_BITS = dcle_pkg::TIME_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [47:0]         cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire dcle_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output dcle_pkg::out_item_t      out_data
);

  localparam int QW = $clog2(dcle_pkg::OQ_DEPTH) + 1;

  logic [47:0]          mac_address;
  logic [15:0]          retry_base_ms;
  logic                 accept;
  logic [31:0]          cur_xid;
  dcle_pkg::msg_info_t  info;
  dcle_pkg::phase_t     phase;
  dcle_pkg::out_item_t  res0, res1;
  logic [1:0]           n_res, push;
  logic [QW-1:0]        level;

  assign accept = in_valid && !in_stall;
  assign push   = accept ? n_res : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mac_address   <= '0;
      retry_base_ms <= dcle_pkg::RETRY_BASE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dcle_pkg::CFG_MAC:   mac_address   <= cfg_wdata;
        dcle_pkg::CFG_RETRY: retry_base_ms <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  dcle_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (accept && in_data.mode == dcle_pkg::MODE_BYTE),
    .rx_byte   (in_data.rx_byte),
    .last_byte (in_data.last_byte),
    .cur_xid   (cur_xid),
    .mac       (mac_address),
    .info      (info)
  );

  dcle_fsm #(.TIME_BITS(TIME_BITS)) u_fsm (
    .clk        (clk),
    .rst        (rst),
    .take       (accept),
    .item       (in_data),
    .info       (info),
    .retry_base (retry_base_ms),
    .cur_xid    (cur_xid),
    .phase      (phase),
    .res0       (res0),
    .res1       (res1),
    .n_res      (n_res)
  );

  dcle_outq #(.DEPTH(dcle_pkg::OQ_DEPTH)) u_outq (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .d0          (res0),
    .d1          (res1),
    .nearly_full (in_stall),
    .level       (level),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  a_start_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.mode == dcle_pkg::MODE_START |=> out_valid)
    else $error("start transaction produced no result");

  a_start_selects: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.mode == dcle_pkg::MODE_START |=> phase == dcle_pkg::PH_SELECTING)
    else $error("client not selecting after start");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    level <= QW'(dcle_pkg::OQ_DEPTH))
    else $error("result queue overflow");

endmodule
`default_nettype wire

/* sim/dhcp_client_lease_engine_top_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// dhcp_client_lease_engine_top_tb
// Drives start, tick, message-byte and unused-mode items into the engine,
// predicts results with a behavioural copy of the client and parser or typed
// rows, and checks them field by field under varied idling and stalling.
// ---------------------------------------------------------------------------
module dhcp_client_lease_engine_top_tb;
  import dcle_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  typedef struct {
    in_item_t  it;
    int        n_typed;   // -1: use the predictor
    out_item_t typed;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [47:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  dhcp_client_lease_engine_top u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #6 clk = ~clk;

  // client model state
  logic [47:0] mac_addr = '0;
  logic [15:0] retry_base = RETRY_BASE_RST;
  phase_t      cl_phase = PH_IDLE;
  logic [31:0] cl_xid = '0, offer_ip = '0, offer_srv = '0;
  logic [47:0] send_due = '0, renew_due = '0;
  int          retries = 0;
  int          hdr_pos = 0;
  bit          hdr_ok = 1'b1;
  opt_phase_t  opt_ph = OP_CODE;
  logic [7:0]  opt_code = '0, opt_left = '0;
  logic [31:0] opt_val = '0;
  int          opt_cnt = 0;
  logic [7:0]  got_type = '0;
  logic [31:0] got_mask = '0, got_router = '0, got_dns = '0, got_srv = '0;
  logic [31:0] got_lease = '0, got_yaddr = '0;

  out_item_t lease_results_q[$];
  out_item_t step_results[$];
  logic [7:0] msg_bytes[$];
  out_item_t rx_want;

  int errors = 0;
  int items_sent = 0;
  int quiet = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0, hold_seen = 0, hold_left = 0;
  logic [47:0] clock_ms = '0;

  function automatic out_item_t mk(logic [1:0] act, logic [31:0] xid, logic [31:0] req,
                                   logic [31:0] srv, logic [31:0] addr, logic [31:0] mask,
                                   logic [31:0] gw, logic [31:0] dns);
    out_item_t r;
    r.action = act; r.transaction_id = xid; r.requested_ip = req; r.server_ip = srv;
    r.leased_address = addr; r.subnet_mask = mask; r.gateway_ip = gw;
    r.name_server_ip = dns; r.last_result = 1'b0;
    return r;
  endfunction

  function automatic in_item_t itm(logic [1:0] m, logic [47:0] now, logic [7:0] b,
                                   logic l, logic [31:0] xid);
    in_item_t r;
    r.mode = m; r.now_ms = now; r.rx_byte = b; r.last_byte = l; r.random_xid = xid;
    return r;
  endfunction

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  task automatic clear_parser();
    hdr_pos = 0; hdr_ok = 1'b1; opt_ph = OP_CODE; opt_code = '0; opt_left = '0;
    opt_val = '0; opt_cnt = 0; got_type = '0; got_mask = '0; got_router = '0;
    got_dns = '0; got_srv = '0; got_lease = '0; got_yaddr = '0;
  endtask

  task automatic restart_client(logic [47:0] now, logic [31:0] xid);
    cl_xid = xid; cl_phase = PH_SELECTING; retries = 0;
    send_due = now + {32'd0, retry_base};
    step_results.push_back(mk(ACT_DISCOVER, cl_xid, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic commit_option();
    if (opt_code == OPT_TYPE) begin
      if (opt_cnt >= 1 && opt_cnt <= 4) got_type = opt_val[8*(opt_cnt-1) +: 8];
    end else if (opt_cnt >= 4) begin
      case (opt_code)
        OPT_MASK:   got_mask = opt_val;
        OPT_ROUTER: got_router = opt_val;
        OPT_DNS:    got_dns = opt_val;
        OPT_SERVER: got_srv = opt_val;
        OPT_LEASE:  got_lease = opt_val;
        default: ;
      endcase
    end
  endtask

  task automatic finish_message(logic [47:0] now, logic [31:0] xid);
    logic [47:0] secs;
    if (cl_phase == PH_IDLE) return;
    if (got_type == MSG_OFFER && cl_phase == PH_SELECTING) begin
      offer_ip = got_yaddr; offer_srv = got_srv; cl_phase = PH_REQUESTING; retries = 0;
      send_due = now + {32'd0, retry_base};
      step_results.push_back(mk(ACT_REQUEST, cl_xid, offer_ip, offer_srv, 0, 0, 0, 0));
    end else if (got_type == MSG_ACK && cl_phase == PH_REQUESTING) begin
      secs = (got_lease != 0 && got_lease < LEASE_LIMIT_S) ? {16'd0, got_lease >> 1}
                                                           : 48'd86400;
      if (secs == 0) secs = 48'd1;
      cl_phase = PH_BOUND;
      renew_due = now + secs * 48'd1000;
      step_results.push_back(mk(ACT_BOUND, 0, 0, 0, got_yaddr,
                                got_mask != 0 ? got_mask : DEF_NETMASK, got_router, got_dns));
    end else if (got_type == MSG_NAK) begin
      step_results.push_back(mk(ACT_RELEASED, 0, 0, 0, 0, 0, 0, 0));
      restart_client(now, xid);
    end
  endtask

  // Works out the results of one accepted transaction into step_results.
  task automatic predict_lease_step(in_item_t it);
    logic [7:0] b, want;
    logic [47:0] base48;
    int p, sh;
    b = it.rx_byte;
    step_results.delete();
    if (it.mode == MODE_START) begin
      restart_client(it.now_ms, it.random_xid);
    end else if (it.mode == MODE_TICK) begin
      if (cl_phase == PH_BOUND) begin
        if (it.now_ms >= renew_due) begin
          cl_phase = PH_REQUESTING; retries = 0;
          send_due = it.now_ms + {32'd0, retry_base};
          step_results.push_back(mk(ACT_REQUEST, cl_xid, offer_ip, offer_srv, 0, 0, 0, 0));
        end
      end else if (cl_phase != PH_IDLE && it.now_ms >= send_due) begin
        if (retries < 4) retries++;
        sh = retries < 3 ? retries : 3;
        base48 = {32'd0, retry_base};
        send_due = it.now_ms + (base48 << sh);
        if (cl_phase == PH_REQUESTING && retries > 3)
          restart_client(it.now_ms, it.random_xid);
        else if (cl_phase == PH_REQUESTING)
          step_results.push_back(mk(ACT_REQUEST, cl_xid, offer_ip, offer_srv, 0, 0, 0, 0));
        else
          step_results.push_back(mk(ACT_DISCOVER, cl_xid, 0, 0, 0, 0, 0, 0));
      end
    end else if (it.mode == MODE_BYTE) begin
      p = hdr_pos;
      if (p < 240) begin
        want = b;
        if (p == 0) want = 8'd2;
        else if (p >= 4 && p < 8) want = cl_xid[31-8*(p-4) -: 8];
        else if (p >= 16 && p < 20) got_yaddr = {got_yaddr[23:0], b};
        else if (p >= 28 && p < 34) want = mac_addr[47-8*(p-28) -: 8];
        else if (p >= 236) want = MAGIC_COOKIE[31-8*(p-236) -: 8];
        if (want != b) hdr_ok = 1'b0;
        hdr_pos = p + 1;
      end else begin
        case (opt_ph)
          OP_CODE: begin
            if (b == OPT_END) opt_ph = OP_DONE;
            else if (b != OPT_PAD) begin
              opt_code = b; opt_ph = OP_LEN;
            end
          end
          OP_LEN: begin
            opt_left = b; opt_val = '0; opt_cnt = 0;
            opt_ph = (b == 0) ? OP_CODE : OP_VALUE;
          end
          OP_VALUE: begin
            if (opt_cnt < 4) begin
              opt_val = {opt_val[23:0], b}; opt_cnt++;
            end
            opt_left = opt_left - 8'd1;
            if (opt_left == 0) begin
              commit_option(); opt_ph = OP_CODE;
            end
          end
          default: ;
        endcase
      end
      if (it.last_byte) begin
        if (p >= 239 && hdr_ok) finish_message(it.now_ms, it.random_xid);
        clear_parser();
      end
    end
    if (step_results.size() > 0) step_results[$].last_result = 1'b1;
  endtask

  // Offers one transaction, waits for it to be taken, then queues its results.
  task automatic push(in_item_t it, int n_typed, out_item_t typed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predict_lease_step(it);
    if (n_typed < 0) foreach (step_results[i]) lease_results_q.push_back(step_results[i]);
    else if (n_typed == 1) lease_results_q.push_back(typed);
    if (it.mode != 2'd3) items_sent++;
  endtask

  task automatic send(in_item_t it);
    push(it, -1, '0);
  endtask

  task automatic tick(bit fire);
    logic [47:0] due;
    due = (cl_phase == PH_BOUND) ? renew_due : send_due;
    clock_ms = fire ? due + $urandom_range(3) : due - $urandom_range(1, 50);
    send(itm(MODE_TICK, clock_ms, 8'($urandom), 1'($urandom), $urandom));
  endtask

  task automatic add_opt(logic [7:0] code, int len, logic [31:0] val);
    int kk;
    kk = len < 4 ? len : 4;
    msg_bytes.push_back(code);
    msg_bytes.push_back(len[7:0]);
    for (int k = 0; k < len; k++)
      msg_bytes.push_back(k < kk ? val[8*(kk-1-k) +: 8] : 8'($urandom));
  endtask

  function automatic int addr_len();
    return $urandom_range(9) != 0 ? 4 : $urandom_range(0, 6);
  endfunction

  function automatic logic [31:0] pick_lease();
    case ($urandom_range(7))
      0: return 32'd0;
      1: return $urandom_range(1, 3);
      2: return 32'd172799;
      3: return LEASE_LIMIT_S;
      4: return 32'hFFFF_FFFF;
      5: return $urandom;
      default: return $urandom_range(4, 60);
    endcase
  endfunction

  // flaw: 0 clean, 1 header mismatch, 2 short, 3 option cut off,
  // 4 bytes after end, 5 noise in the option area
  task automatic build_msg(logic [7:0] mtype, int flaw);
    int order[7];
    int j, tmp, n;
    logic [31:0] yaddr;
    int bad_pos[15] = '{0, 4, 5, 6, 7, 28, 29, 30, 31, 32, 33, 236, 237, 238, 239};
    yaddr = $urandom;
    msg_bytes.delete();
    for (int i = 0; i < 240; i++) begin
      if (i == 0) msg_bytes.push_back(8'd2);
      else if (i >= 4 && i < 8) msg_bytes.push_back(cl_xid[31-8*(i-4) -: 8]);
      else if (i >= 16 && i < 20) msg_bytes.push_back(yaddr[31-8*(i-16) -: 8]);
      else if (i >= 28 && i < 34) msg_bytes.push_back(mac_addr[47-8*(i-28) -: 8]);
      else if (i >= 236) msg_bytes.push_back(MAGIC_COOKIE[31-8*(i-236) -: 8]);
      else msg_bytes.push_back(8'($urandom));
    end
    if (flaw == 1) begin
      j = bad_pos[$urandom_range(14)];
      msg_bytes[j] = msg_bytes[j] ^ (8'd1 << $urandom_range(7));
    end
    if (flaw == 5) begin
      repeat ($urandom_range(0, 20)) msg_bytes.push_back(8'($urandom));
    end else begin
      for (int i = 0; i < 7; i++) order[i] = i;
      for (int i = 0; i < 7; i++) begin
        j = $urandom_range(6); tmp = order[i]; order[i] = order[j]; order[j] = tmp;
      end
      foreach (order[i]) begin
        case (order[i])
          0: add_opt(OPT_TYPE, $urandom_range(4) != 0 ? 1 : $urandom_range(0, 6), mtype);
          1: add_opt(OPT_SERVER, addr_len(), $urandom);
          2: add_opt(OPT_LEASE, addr_len(), pick_lease());
          3: if ($urandom_range(1)) add_opt(OPT_MASK, addr_len(), $urandom);
          4: if ($urandom_range(3) != 0) add_opt(OPT_ROUTER, addr_len(), $urandom);
          5: if ($urandom_range(3) != 0) add_opt(OPT_DNS, addr_len(), $urandom);
          default: begin
            repeat ($urandom_range(0, 2)) msg_bytes.push_back(OPT_PAD);
            if ($urandom_range(1)) add_opt(8'($urandom_range(7, 50)), $urandom_range(0, 3),
                                           $urandom);
          end
        endcase
      end
    end
    if (flaw == 3) begin
      msg_bytes.push_back($urandom_range(1) ? OPT_TYPE : OPT_SERVER);
      msg_bytes.push_back(8'd4);
      repeat ($urandom_range(0, 3)) msg_bytes.push_back(MSG_NAK);
    end else begin
      msg_bytes.push_back(OPT_END);
      if (flaw == 4) begin
        add_opt(OPT_TYPE, 1, MSG_NAK);
        repeat ($urandom_range(0, 4)) msg_bytes.push_back(8'($urandom));
      end
    end
    if (flaw == 2) begin
      n = $urandom_range(1, 239);
      while (msg_bytes.size() > n) void'(msg_bytes.pop_back());
    end
  endtask

  task automatic send_msg();
    logic [47:0] now;
    foreach (msg_bytes[i]) begin
      now = ($urandom_range(19) == 0) ? rand48() : clock_ms;
      send(itm(MODE_BYTE, now, msg_bytes[i], i == msg_bytes.size() - 1, $urandom));
    end
  endtask

  function automatic int pick_flaw();
    int r;
    r = $urandom_range(19);
    return (r >= 13 && r <= 17) ? r - 12 : 0;
  endfunction

  // one step of a lease: optional restart, ticks and stray item, then a
  // message chosen for the client's phase
  task automatic lease_episode();
    int r;
    if (cl_phase == PH_IDLE || $urandom_range(5) == 0) begin
      if ($urandom_range(9) == 0) clock_ms = rand48();
      send(itm(MODE_START, clock_ms, 8'($urandom), 1'($urandom), $urandom));
    end
    repeat ($urandom_range(0, 4)) tick($urandom_range(3) != 0);
    if ($urandom_range(9) == 0)
      send(itm(2'd3, rand48(), 8'($urandom), 1'($urandom), $urandom));
    if (cl_phase == PH_BOUND && $urandom_range(2) != 0) begin
      tick(1'b0);
      tick(1'b1);
    end
    r = $urandom_range(9);
    if (cl_phase == PH_SELECTING)
      build_msg($urandom_range(4) != 0 ? MSG_OFFER : 8'($urandom_range(0, 7)), pick_flaw());
    else if (cl_phase == PH_REQUESTING)
      build_msg(r < 7 ? MSG_ACK : (r < 9 ? MSG_NAK : 8'($urandom)), pick_flaw());
    else
      build_msg(MSG_NAK, 0);
    send_msg();
  endtask

  task automatic cfg_write(logic idx, logic [47:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_MAC) mac_addr = val;
    else retry_base = val[15:0];
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (lease_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic dir_row_t row(logic [1:0] m, logic [47:0] now, logic [7:0] b,
                                   logic l, logic [31:0] xid, int n, bit disc);
    dir_row_t r;
    r.it = itm(m, now, b, l, xid);
    r.n_typed = n;
    r.typed = disc ? mk(ACT_DISCOVER, xid, 0, 0, 0, 0, 0, 0) : '0;
    if (disc) r.typed.last_result = 1'b1;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // receiving side: checks, stalls, watchdog
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (lease_results_q.size() == 0) begin
        $display("%0t: unexpected result, expected none got action %0d", $time,
                 out_data.action);
        errors++;
      end else begin
        rx_want = lease_results_q.pop_front();
        check_field("action", rx_want.action, out_data.action);
        check_field("transaction_id", rx_want.transaction_id, out_data.transaction_id);
        check_field("requested_ip", rx_want.requested_ip, out_data.requested_ip);
        check_field("server_ip", rx_want.server_ip, out_data.server_ip);
        check_field("leased_address", rx_want.leased_address, out_data.leased_address);
        check_field("subnet_mask", rx_want.subnet_mask, out_data.subnet_mask);
        check_field("gateway_ip", rx_want.gateway_ip, out_data.gateway_ip);
        check_field("name_server_ip", rx_want.name_server_ip, out_data.name_server_ip);
        check_field("last_result", rx_want.last_result, out_data.last_result);
      end
    end
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("dhcp_client_lease_engine_top_tb: errors");
      $finish;
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 80;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    dir_row_t dir_rows[$];
    int items_mark;
    int send_set[4] = '{0, 70, 0, 29};
    int stall_set[4] = '{0, 0, 70, 29};
    logic [47:0] mac_set[4];
    logic [15:0] base_set[4];
    mac_set = '{48'h0, 48'hFFFF_FFFF_FFFF, rand48(), rand48()};
    base_set = '{16'd1, 16'hFFFF, 16'd0, 16'($urandom_range(1, 65535))};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // single-transaction corner cases
    dir_rows.push_back(row(MODE_TICK, 48'd0, 8'd0, 1'b0, 32'd0, 0, 0));
    dir_rows.push_back(row(MODE_BYTE, 48'd0, 8'd2, 1'b1, 32'd0, 0, 0));
    dir_rows.push_back(row(2'd3, 48'hFFFF_FFFF_FFFF, 8'hFF, 1'b1, 32'hFFFF_FFFF, 0, 0));
    dir_rows.push_back(row(MODE_START, 48'd0, 8'd0, 1'b0, 32'hFFFF_FFFF, 1, 1));
    dir_rows.push_back(row(MODE_TICK, 48'd0, 8'd0, 1'b0, 32'd0, -1, 0));
    dir_rows.push_back(row(MODE_TICK, 48'd2000, 8'd0, 1'b0, 32'd0, -1, 0));
    dir_rows.push_back(row(MODE_TICK, 48'd100000, 8'd0, 1'b0, 32'd0, -1, 0));
    dir_rows.push_back(row(MODE_TICK, 48'd200000, 8'd0, 1'b0, 32'd0, -1, 0));
    dir_rows.push_back(row(MODE_TICK, 48'd300000, 8'd0, 1'b0, 32'd0, -1, 0));
    dir_rows.push_back(row(MODE_TICK, 48'd400000, 8'd0, 1'b0, 32'd0, -1, 0));
    dir_rows.push_back(row(MODE_START, 48'hFFFF_FFFF_FFFF, 8'd0, 1'b0, 32'd0, 1, 1));
    dir_rows.push_back(row(MODE_TICK, 48'hFFFF_FFFF_FFFF, 8'hFF, 1'b1, 32'hFFFF_FFFF, -1, 0));
    dir_rows.push_back(row(MODE_BYTE, 48'd5, 8'hFF, 1'b0, 32'd0, -1, 0));
    dir_rows.push_back(row(MODE_BYTE, 48'd5, 8'h00, 1'b1, 32'd0, 0, 0));
    dir_rows.push_back(row(MODE_START, 48'd7, 8'h00, 1'b0, 32'h5A5A_A5A5, 1, 1));

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      cfg_write(CFG_MAC, mac_set[ph]);
      cfg_write(CFG_RETRY, {32'd0, base_set[ph]});
      cfg_we <= 1'b0;
      send_idle_pct = send_set[ph];
      stall_pct = stall_set[ph];
      if (ph == 0)
        foreach (dir_rows[i]) push(dir_rows[i].it, dir_rows[i].n_typed, dir_rows[i].typed);
      items_mark = items_sent;
      while (items_sent - items_mark < 200)
        lease_episode();
    end

    // hold the receiver off while starts keep coming, so the block backs up
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req++;
    repeat (12) send(itm(MODE_START, clock_ms, 8'($urandom), 1'($urandom), $urandom));

    in_valid <= 1'b0;
    while (lease_results_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) $display("dhcp_client_lease_engine_top_tb: clean");
    else $display("dhcp_client_lease_engine_top_tb: errors");
    $finish;
  end

endmodule
